// ===== rtl/console_line_edit_buffer_macros.svh =====
// assertion macros used by the line edit buffer rtl
`ifndef CONSOLE_LINE_EDIT_BUFFER_MACROS_SVH
`define CONSOLE_LINE_EDIT_BUFFER_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define CLEB_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("line edit buffer check failed");

// condition in this cycle implies consequence in the next cycle
`define CLEB_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("line edit buffer check failed");

`endif

// ===== rtl/cleb_pkg.sv =====
// shared types and constants of the console line edit buffer
`default_nettype none

package cleb_pkg;

    // ring depth, a power of two; positions run modulo twice the depth
    localparam int BUF_DEPTH = 512;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int POS_W     = IDX_W + 1;
    localparam int ERASE_W   = 10;

    // control characters
    localparam logic [7:0] KEY_NUL  = 8'h00;
    localparam logic [7:0] KEY_BS   = 8'h08;
    localparam logic [7:0] KEY_DEL  = 8'h7f;
    localparam logic [7:0] KEY_KILL = 8'h15;
    localparam logic [7:0] KEY_EOF  = 8'h04;
    localparam logic [7:0] KEY_DUMP = 8'h10;
    localparam logic [7:0] KEY_CR   = 8'h0d;
    localparam logic [7:0] KEY_LF   = 8'h0a;

    // item kinds
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef enum logic [1:0] {
        RS_DATA = 2'd0,
        RS_EOF  = 2'd1,
        RS_WAIT = 2'd2
    } rstat_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] key_code;
        logic       read_has_bytes;
    } item_t;

    typedef struct packed {
        logic               echo_valid;
        logic [7:0]         echo_char;
        logic [ERASE_W-1:0] erase_count;
        logic               line_ready;
        logic [7:0]         read_byte;
        rstat_t             read_status;
        logic               read_ends;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/console_line_edit_buffer.sv =====
// console line edit buffer: canonical line editing over a character ring
//
// A beat is taken on item when start is high and busy is low. mode 0 feeds
// one keyboard byte, mode 1 pops one committed byte for a reader. Each item
// gives exactly one result beat on result, marked by done for one cycle;
// the receiver has no way to stall and must take it then.
// Steps from accept to done: a stored or ignored key, a backspace, a kill with
// nothing to erase and a read with nothing committed answer straight from idle;
// a read of a committed byte first does one ring read; a kill walks the ring
// backward, erasing one character per ring read until a newline or the commit
// point, up to BUF_DEPTH characters. busy is high only while such a read or
// kill is in progress and is low again when done rises; a new item may be
// accepted in the done cycle itself.
// Reset clears the read, commit and edit positions; the ring itself is not
// cleared and holds no valid bits, as nothing is read before it is written.
// No configuration; the ring depth is a package constant.
`default_nettype none

module console_line_edit_buffer
    import cleb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire item_t   item,
    output logic         done,
    output result_t      result
);

`include "console_line_edit_buffer_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_KILL,
        S_READ
    } state_t;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] read_pos_reg, read_pos_next;
    logic [POS_W-1:0] commit_pos_reg, commit_pos_next;
    logic [POS_W-1:0] edit_pos_reg, edit_pos_next;
    logic             has_bytes_reg, has_bytes_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    logic [POS_W-1:0] fill;
    logic [POS_W-1:0] edit_prev;
    logic [7:0]       store_char;

    cleb_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // characters held between reader and editor
    assign fill       = edit_pos_reg - read_pos_reg;
    assign store_char = (item.key_code == KEY_CR) ? KEY_LF : item.key_code;

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        read_pos_next   = read_pos_reg;
        commit_pos_next = commit_pos_reg;
        edit_pos_next   = edit_pos_reg;
        has_bytes_next  = has_bytes_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        wr_en           = 1'b0;
        wr_addr         = edit_pos_reg[IDX_W-1:0];
        wr_data         = store_char;
        edit_prev       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    result_next             = '0;
                    result_next.read_status = RS_WAIT;
                    has_bytes_next          = item.read_has_bytes;
                    if (item.mode == MODE_READ)
                    begin
                        // nothing committed answers at once
                        if (read_pos_reg == commit_pos_reg)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        case (item.key_code)
                            KEY_KILL:
                            begin
                                if (edit_pos_reg == commit_pos_reg)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_KILL;
                                end
                            end
                            KEY_BS, KEY_DEL:
                            begin
                                if (edit_pos_reg != commit_pos_reg)
                                begin
                                    edit_pos_next           = edit_pos_reg - POS_W'(1);
                                    result_next.erase_count = ERASE_W'(1);
                                end
                                done_next = 1'b1;
                            end
                            KEY_NUL, KEY_DUMP:
                            begin
                                done_next = 1'b1;
                            end
                            default:
                            begin
                                // store and echo when the ring has room
                                if (!fill[POS_W-1])
                                begin
                                    wr_en                  = 1'b1;
                                    edit_pos_next          = edit_pos_reg + POS_W'(1);
                                    result_next.echo_valid = 1'b1;
                                    result_next.echo_char  = store_char;
                                    if (store_char == KEY_LF || store_char == KEY_EOF ||
                                        fill == POS_W'(BUF_DEPTH - 1))
                                    begin
                                        commit_pos_next        = edit_pos_reg + POS_W'(1);
                                        result_next.line_ready = 1'b1;
                                    end
                                end
                                done_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_KILL:
            begin
                // rd_data holds the character just before the edit point
                if (rd_data == KEY_LF)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    edit_pos_next           = edit_pos_reg - POS_W'(1);
                    result_next.erase_count = result_reg.erase_count + ERASE_W'(1);
                    if (edit_pos_next == commit_pos_reg)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                // rd_data holds the oldest committed character
                result_next.read_ends = 1'b1;
                if (rd_data == KEY_EOF)
                begin
                    result_next.read_status = RS_EOF;
                    if (!has_bytes_reg)
                    begin
                        read_pos_next = read_pos_reg + POS_W'(1);
                    end
                end
                else
                begin
                    result_next.read_status = RS_DATA;
                    result_next.read_byte   = rd_data;
                    result_next.read_ends   = (rd_data == KEY_LF);
                    read_pos_next           = read_pos_reg + POS_W'(1);
                end
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // ring read address for the next cycle
        edit_prev = edit_pos_next - POS_W'(1);
        if (state_next == S_KILL)
        begin
            rd_addr = edit_prev[IDX_W-1:0];
        end
        else
        begin
            rd_addr = read_pos_reg[IDX_W-1:0];
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            read_pos_reg   <= '0;
            commit_pos_reg <= '0;
            edit_pos_reg   <= '0;
            has_bytes_reg  <= 1'b0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            read_pos_reg   <= read_pos_next;
            commit_pos_reg <= commit_pos_next;
            edit_pos_reg   <= edit_pos_next;
            has_bytes_reg  <= has_bytes_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // positions keep reader, commit point and editor in order within the ring
    `CLEB_ASSERT_SAME(a_pos_order, 1'b1,
        ((commit_pos_reg - read_pos_reg) <= fill) && (fill <= POS_W'(BUF_DEPTH)))
    // an accepted item either keeps the block busy or answers next cycle
    `CLEB_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
    // a committed line always comes with the echo of its last character
    `CLEB_ASSERT_SAME(a_ready_echo, done_reg && result_reg.line_ready,
        result_reg.echo_valid && (result_reg.read_status == RS_WAIT))

endmodule

`default_nettype wire

// ===== rtl/cleb_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module cleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== verif/tb_console_line_edit_buffer.sv =====
// self-checking testbench of the console line edit buffer
`default_nettype none

module tb_console_line_edit_buffer
    import cleb_pkg::*;
;

    // line discipline predictor plus the queue of result beats it expects
    class line_edit_board;
        bit [7:0]         ring [BUF_DEPTH];
        logic [POS_W-1:0] rd_pos;
        logic [POS_W-1:0] cm_pos;
        logic [POS_W-1:0] ed_pos;
        result_t          pending_results [$];
        int               fails;

        function new();
            rd_pos = '0;
            cm_pos = '0;
            ed_pos = '0;
            fails  = 0;
        endfunction

        // apply one accepted beat to the predicted state and queue its result
        function void note_item(item_t it);
            result_t          r;
            logic [7:0]       c;
            logic [POS_W-1:0] prev;
            logic [POS_W-1:0] occ;
            r = '0;
            r.read_status = RS_WAIT;
            if (it.mode == MODE_KEY)
            begin
                occ = ed_pos - rd_pos;
                if (it.key_code == KEY_KILL)
                begin
                    // walk back to the commit point or a newline
                    prev = ed_pos - POS_W'(1);
                    while (ed_pos != cm_pos && ring[prev[IDX_W-1:0]] != KEY_LF)
                    begin
                        ed_pos = prev;
                        r.erase_count = r.erase_count + ERASE_W'(1);
                        prev = ed_pos - POS_W'(1);
                    end
                end
                else if (it.key_code == KEY_BS || it.key_code == KEY_DEL)
                begin
                    if (ed_pos != cm_pos)
                    begin
                        ed_pos = ed_pos - POS_W'(1);
                        r.erase_count = ERASE_W'(1);
                    end
                end
                else if (it.key_code != KEY_NUL && it.key_code != KEY_DUMP &&
                         occ < POS_W'(BUF_DEPTH))
                begin
                    // store with cr mapped to lf, commit on lf, eof or full
                    c = (it.key_code == KEY_CR) ? KEY_LF : it.key_code;
                    ring[ed_pos[IDX_W-1:0]] = c;
                    ed_pos = ed_pos + POS_W'(1);
                    r.echo_valid = 1'b1;
                    r.echo_char = c;
                    occ = ed_pos - rd_pos;
                    if (c == KEY_LF || c == KEY_EOF || occ == POS_W'(BUF_DEPTH))
                    begin
                        cm_pos = ed_pos;
                        r.line_ready = 1'b1;
                    end
                end
            end
            else if (rd_pos != cm_pos)
            begin
                c = ring[rd_pos[IDX_W-1:0]];
                if (c == KEY_EOF)
                begin
                    // eof stays buffered when the read call already has bytes
                    if (!it.read_has_bytes)
                        rd_pos = rd_pos + POS_W'(1);
                    r.read_status = RS_EOF;
                    r.read_ends = 1'b1;
                end
                else
                begin
                    rd_pos = rd_pos + POS_W'(1);
                    r.read_status = RS_DATA;
                    r.read_byte = c;
                    r.read_ends = (c == KEY_LF);
                end
            end
            pending_results.push_back(r);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat %h", got);
                fails++;
                return;
            end
            want = pending_results.pop_front();
            if (got.echo_valid !== want.echo_valid)
            begin
                $error("echo_valid: expected %0h, actual %0h", want.echo_valid, got.echo_valid);
                fails++;
            end
            if (got.echo_char !== want.echo_char)
            begin
                $error("echo_char: expected %0h, actual %0h", want.echo_char, got.echo_char);
                fails++;
            end
            if (got.erase_count !== want.erase_count)
            begin
                $error("erase_count: expected %0d, actual %0d",
                       want.erase_count, got.erase_count);
                fails++;
            end
            if (got.line_ready !== want.line_ready)
            begin
                $error("line_ready: expected %0h, actual %0h", want.line_ready, got.line_ready);
                fails++;
            end
            if (got.read_byte !== want.read_byte)
            begin
                $error("read_byte: expected %0h, actual %0h", want.read_byte, got.read_byte);
                fails++;
            end
            if (got.read_status !== want.read_status)
            begin
                $error("read_status: expected %0d, actual %0d",
                       want.read_status, got.read_status);
                fails++;
            end
            if (got.read_ends !== want.read_ends)
            begin
                $error("read_ends: expected %0h, actual %0h", want.read_ends, got.read_ends);
                fails++;
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    item_t          item_in = '0;
    logic           busy;
    logic           done;
    result_t        result_out;
    line_edit_board board;
    int             burst_left = 0;
    int             n_sent = 0;

    console_line_edit_buffer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item_in),
        .done   (done),
        .result (result_out)
    );

    always #6 clk = ~clk;

    // result monitor: every done beat is taken as it comes
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_result(result_out);
    end

    // drive one beat, with bursts and random gaps between them
    task automatic send_item(item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
        end
        start <= 1'b1;
        item_in <= it;
        do @(posedge clk); while (busy !== 1'b0);
        board.note_item(it);
        burst_left--;
        n_sent++;
    endtask

    task automatic send_key(logic [7:0] k);
        item_t it;
        it.mode = MODE_KEY;
        it.key_code = k;
        it.read_has_bytes = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_read(logic hb);
        item_t it;
        it.mode = MODE_READ;
        it.key_code = 8'($urandom_range(0, 255));
        it.read_has_bytes = hb;
        send_item(it);
    endtask

    // ordinary character that neither edits nor commits
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                            : 8'($urandom_range(32, 126));
        while (c == KEY_BS || c == KEY_DEL || c == KEY_KILL || c == KEY_EOF ||
               c == KEY_DUMP || c == KEY_CR || c == KEY_LF);
        return c;
    endfunction

    // commit any open line and read everything out
    task automatic drain_ring();
        if (board.ed_pos != board.cm_pos)
            send_key(KEY_LF);
        while (board.rd_pos != board.cm_pos)
            send_read(1'b0);
    endtask

    // stimulus
    initial
    begin
        int     n_random;
        int     base;
        int     n;
        int     sel;
        bit     fill_done;
        bit     kill_done;
        item_t  it;
        n_random  = 0;
        fill_done = 0;
        kill_done = 0;
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, ignored keys, editing, commit and eof
        send_read(1'b0);
        send_read(1'b1);
        send_key(KEY_NUL);
        send_key(KEY_DUMP);
        send_key(KEY_BS);
        send_key(KEY_DEL);
        send_key(KEY_KILL);
        send_key(8'hff);
        send_key(8'h01);
        send_key("a");
        send_key(KEY_BS);
        send_key(KEY_DEL);
        send_key("x");
        send_key("y");
        send_key("z");
        send_key(KEY_KILL);
        send_key("q");
        send_key(KEY_CR);
        send_key(KEY_KILL);
        send_read(1'b1);
        send_read(1'b0);
        send_key(KEY_EOF);
        send_read(1'b1);
        send_read(1'b0);
        send_read(1'b0);

        // random: mostly edited lines followed by reads, some noise
        while (n_random < 1200)
        begin
            base = n_sent;
            if (!fill_done && n_random > 150)
            begin
                // fill the ring to the brim, overflow it, then empty it
                drain_ring();
                repeat (BUF_DEPTH + 6) send_key(plain_char());
                send_key(KEY_BS);
                send_key(KEY_KILL);
                drain_ring();
                fill_done = 1;
            end
            if (!kill_done && n_random > 40)
            begin
                // one long kill over a large uncommitted line
                drain_ring();
                repeat (150) send_key(plain_char());
                send_key(KEY_KILL);
                send_key(KEY_BS);
                kill_done = 1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                // one line with edits, an optional terminator and some reads
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
                for (int i = 0; i < n; i++)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 8)
                        send_key($urandom_range(0, 1) ? KEY_BS : KEY_DEL);
                    else if (sel < 11)
                        send_key(KEY_KILL);
                    else if (sel < 16)
                        send_key(8'($urandom_range(0, 255)));
                    else
                        send_key(plain_char());
                end
                sel = $urandom_range(0, 9);
                if (sel < 4)
                    send_key(KEY_LF);
                else if (sel < 6)
                    send_key(KEY_CR);
                else if (sel < 8)
                    send_key(KEY_EOF);
                repeat ($urandom_range(0, n + 3)) send_read(1'($urandom_range(0, 1)));
            end
            else if (sel < 90)
            begin
                // raw noise over both kinds of beat
                repeat ($urandom_range(1, 12))
                begin
                    it = 10'($urandom_range(0, 1023));
                    send_item(it);
                end
            end
            else
                drain_ring();
            n_random += n_sent - base;
        end

        start <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (board.fails == 0 && board.pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        #(12 * 2000000);
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/cleb_pkg.sv
rtl/cleb_ram.sv
rtl/console_line_edit_buffer.sv
verif/tb_console_line_edit_buffer.sv
